>>> sv/cht_pkg.sv
package cht_pkg;

   localparam int MAX_BUCKETS    = 1024;
   localparam int OVERFLOW_SLOTS = 1024;
   localparam int TOTAL_SLOTS    = MAX_BUCKETS + OVERFLOW_SLOTS;

   localparam int BKT_W  = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int SLOT_W = $clog2(TOTAL_SLOTS);
   localparam int OCNT_W = $clog2(OVERFLOW_SLOTS + 1);
   localparam int ESZ_W  = $clog2(MAX_BUCKETS + 1);
   localparam int TSZ_W  = 11;
   localparam int KEY_W  = 32;
   localparam int VAL_W  = 32;
   localparam int HASH_W = 32;
   localparam int HASH_BYTES = HASH_W / 8;
   localparam int CNT_W  = (BKT_W > 5) ? BKT_W : 5;

   localparam logic [HASH_W-1:0] HASH_SEED  = 32'd5381;
   localparam int                HASH_SHIFT = 5;
   localparam logic [TSZ_W-1:0]  TABLE_SIZE_RESET = 11'd1024;

   localparam logic [1:0] OP_ADD       = 2'd0;
   localparam logic [1:0] OP_FIND      = 2'd1;
   localparam logic [1:0] OP_FIND_NEXT = 2'd2;
   localparam logic [1:0] OP_CLEAR     = 2'd3;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [KEY_W-1:0]  key;
      logic signed [VAL_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic                     found;
      logic signed [VAL_W-1:0]  result_value;
      logic                     status;
   } rsp_type;

   typedef struct packed {
      logic             load;
      logic             hash_step;
      logic             div_step;
      logic             home_rd;
      logic             home_add;
      logic             chain_add;
      logic             link_wr;
      logic             refuse;
      logic             walk_resume;
      logic             walk_hit;
      logic             walk_next;
      logic             clr_step;
      logic             clr_state;
      logic             emit;
      logic [CNT_W-1:0] cnt;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       size_zero;
      logic       resume_none;
      logic       home_used;
      logic       ovf_full;
      logic       walk_used;
      logic       walk_match;
      logic       link_zero;
   } sts_type;

endpackage

>>> sv/cht_ram.sv
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/cht_ctrl.sv
module cht_ctrl import cht_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  sts_type    sts,
   output cmd_type    cmd
);

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_HASH     = 4'd2;
   localparam logic [3:0] S_DIV      = 4'd3;
   localparam logic [3:0] S_HOME_RD  = 4'd4;
   localparam logic [3:0] S_HOME_CHK = 4'd5;
   localparam logic [3:0] S_LINK_WR  = 4'd6;
   localparam logic [3:0] S_WALK_RD  = 4'd7;
   localparam logic [3:0] S_WALK_CHK = 4'd8;
   localparam logic [3:0] S_CLR      = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   localparam logic [CNT_W-1:0] CLR_LAST  = CNT_W'(MAX_BUCKETS - 1);
   localparam logic [CNT_W-1:0] HASH_LAST = CNT_W'(HASH_BYTES - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(HASH_W - 1);

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.cnt      = cnt_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = (state_ff != S_IDLE);
      unique case (state_ff)
         S_INIT, S_CLR: begin
            cmd.clr_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CLR_LAST) begin
               cnt_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               unique case (req_op) inside
                  OP_CLEAR: begin
                     cmd.clr_state = 1'b1;
                     state_in      = S_CLR;
                  end
                  OP_FIND_NEXT: begin
                     if (sts.resume_none) begin
                        state_in = S_DONE;
                     end else begin
                        cmd.walk_resume = 1'b1;
                        state_in        = S_WALK_RD;
                     end
                  end
                  OP_ADD, OP_FIND: begin
                     state_in = sts.size_zero ? S_DONE : S_HASH;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_HASH: begin
            cmd.hash_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == HASH_LAST) begin
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               if (sts.op == OP_ADD) begin
                  state_in = S_HOME_RD;
               end else begin
                  state_in = S_WALK_RD;
               end
            end
         end
         S_HOME_RD: begin
            cmd.home_rd = 1'b1;
            state_in    = S_HOME_CHK;
         end
         S_HOME_CHK: begin
            if (!sts.home_used) begin
               cmd.home_add = 1'b1;
               state_in     = S_DONE;
            end else if (sts.ovf_full) begin
               cmd.refuse = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.chain_add = 1'b1;
               state_in      = S_LINK_WR;
            end
         end
         S_LINK_WR: begin
            cmd.link_wr = 1'b1;
            state_in    = S_DONE;
         end
         S_WALK_RD: begin
            state_in = S_WALK_CHK;
         end
         S_WALK_CHK: begin
            if (!sts.walk_used) begin
               state_in = S_DONE;
            end else if (sts.walk_match) begin
               cmd.walk_hit = 1'b1;
               state_in     = S_DONE;
            end else if (sts.link_zero) begin
               state_in = S_DONE;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = S_WALK_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // after the divider, find walks the chain from the home bucket and add reads the home bucket
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/cht_dpath.sv
module cht_dpath import cht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_item,
   input  logic             csr_valid,
   input  logic [TSZ_W-1:0] csr_data,
   input  cmd_type          cmd,
   output sts_type          sts,
   output rsp_type          rsp_item
);

   localparam logic [SLOT_W-1:0] OVF_BASE = SLOT_W'(MAX_BUCKETS);
   localparam int HOME_W = SLOT_W + 1;
   localparam int KV_W   = KEY_W + VAL_W;

   logic [TSZ_W-1:0]  table_size_ff;
   logic [1:0]        op_ff;
   logic [KEY_W-1:0]  key_ff, cmp_key_ff, resume_key_ff;
   logic [VAL_W-1:0]  value_ff, rv_ff;
   logic [HASH_W-1:0] h_ff;
   logic [ESZ_W-1:0]  rem_ff;
   logic [SLOT_W-1:0] idx_ff, tail_ff, resume_index_ff;
   logic [OCNT_W-1:0] ocount_ff;
   logic              found_ff, status_ff;
   rsp_type           rsp_item_ff;

   logic [ESZ_W-1:0]  eff_size;
   logic [7:0]        hbyte;
   logic [HASH_W-1:0] h_next;
   logic [ESZ_W:0]    rem_shift;
   logic [ESZ_W-1:0]  rem_next;
   logic [BKT_W-1:0]  bucket;
   logic [SLOT_W-1:0] ns;

   logic              home_wr_en;
   logic [BKT_W-1:0]  home_wr_addr, home_rd_addr;
   logic [HOME_W-1:0] home_wr_data, home_rd_data;
   logic              kv_wr_en;
   logic [SLOT_W-1:0] kv_wr_addr;
   logic [KV_W-1:0]   kv_rd_data;
   logic              link_wr_en;
   logic [SLOT_W-1:0] link_wr_addr, link_wr_data, link_rd_data;

   always_comb begin
      if (32'(table_size_ff) > 32'(MAX_BUCKETS)) begin
         eff_size = ESZ_W'(MAX_BUCKETS);
      end else begin
         eff_size = ESZ_W'(table_size_ff);
      end
   end

   // djb2-xor step: h*33 xor sign-extended byte
   assign hbyte  = key_ff[8*cmd.cnt[1:0] +: 8];
   assign h_next = ((h_ff << HASH_SHIFT) + h_ff) ^ {{(HASH_W-8){hbyte[7]}}, hbyte};

   // one quotient bit per step, only the remainder kept
   assign rem_shift = {rem_ff, h_ff[HASH_W-1]};
   always_comb begin
      if (rem_shift >= {1'b0, eff_size}) begin
         rem_next = ESZ_W'(rem_shift - {1'b0, eff_size});
      end else begin
         rem_next = rem_shift[ESZ_W-1:0];
      end
   end

   assign bucket = rem_ff[BKT_W-1:0];
   assign ns     = OVF_BASE + SLOT_W'(ocount_ff);

   always_comb begin
      home_wr_en   = cmd.clr_step || cmd.home_add || cmd.chain_add;
      home_wr_addr = cmd.clr_step ? cmd.cnt[BKT_W-1:0] : bucket;
      if (cmd.clr_step) begin
         home_wr_data = '0;
      end else if (cmd.home_add) begin
         home_wr_data = {1'b1, SLOT_W'(bucket)};
      end else begin
         home_wr_data = {1'b1, ns};
      end
      home_rd_addr = cmd.home_rd ? bucket : idx_ff[BKT_W-1:0];

      kv_wr_en   = cmd.home_add || cmd.chain_add;
      kv_wr_addr = cmd.home_add ? SLOT_W'(bucket) : ns;

      link_wr_en = cmd.home_add || cmd.chain_add || cmd.link_wr;
      if (cmd.home_add) begin
         link_wr_addr = SLOT_W'(bucket);
      end else if (cmd.chain_add) begin
         link_wr_addr = ns;
      end else begin
         link_wr_addr = tail_ff;
      end
      link_wr_data = cmd.link_wr ? ns : '0;
   end

   cht_ram #(.WIDTH(HOME_W), .DEPTH(MAX_BUCKETS)) u_home_ram (
      .clock   (clock),
      .wr_en   (home_wr_en),
      .wr_addr (home_wr_addr),
      .wr_data (home_wr_data),
      .rd_addr (home_rd_addr),
      .rd_data (home_rd_data)
   );

   cht_ram #(.WIDTH(KV_W), .DEPTH(TOTAL_SLOTS)) u_kv_ram (
      .clock   (clock),
      .wr_en   (kv_wr_en),
      .wr_addr (kv_wr_addr),
      .wr_data ({key_ff, value_ff}),
      .rd_addr (idx_ff),
      .rd_data (kv_rd_data)
   );

   cht_ram #(.WIDTH(SLOT_W), .DEPTH(TOTAL_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (idx_ff),
      .rd_data (link_rd_data)
   );

   always_comb begin
      sts             = '0;
      sts.op          = op_ff;
      sts.size_zero   = (eff_size == '0);
      sts.resume_none = (resume_index_ff == '0);
      sts.home_used   = home_rd_data[SLOT_W];
      sts.ovf_full    = (ocount_ff >= OCNT_W'(OVERFLOW_SLOTS));
      if (idx_ff < OVF_BASE) begin
         sts.walk_used = home_rd_data[SLOT_W];
      end else begin
         sts.walk_used = ((idx_ff - OVF_BASE) < SLOT_W'(ocount_ff));
      end
      sts.walk_match  = (kv_rd_data[KV_W-1:VAL_W] == cmp_key_ff);
      sts.link_zero   = (link_rd_data == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff   <= TABLE_SIZE_RESET;
         ocount_ff       <= '0;
         resume_index_ff <= '0;
         resume_key_ff   <= '0;
      end else begin
         if (csr_valid) begin
            table_size_ff <= csr_data;
         end
         if (cmd.clr_state) begin
            ocount_ff       <= '0;
            resume_index_ff <= '0;
         end
         if (cmd.link_wr) begin
            ocount_ff <= ocount_ff + 1'b1;
         end
         if (cmd.walk_hit) begin
            resume_index_ff <= link_rd_data;
            resume_key_ff   <= cmp_key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_item.op;
         key_ff    <= req_item.key;
         value_ff  <= req_item.value;
         h_ff      <= HASH_SEED;
         rem_ff    <= '0;
         found_ff  <= 1'b0;
         rv_ff     <= '0;
         status_ff <= 1'b0;
      end
      if (cmd.hash_step) begin
         h_ff <= h_next;
      end
      if (cmd.div_step) begin
         h_ff   <= h_ff << 1;
         rem_ff <= rem_next;
      end
      if (cmd.walk_resume) begin
         cmp_key_ff <= resume_key_ff;
         idx_ff     <= resume_index_ff;
      end else if (cmd.load) begin
         cmp_key_ff <= req_item.key;
      end
      if (cmd.div_step) begin
         idx_ff <= SLOT_W'(rem_next[BKT_W-1:0]);
      end
      if (cmd.walk_next) begin
         idx_ff <= link_rd_data;
      end
      if (cmd.chain_add) begin
         tail_ff <= home_rd_data[SLOT_W-1:0];
      end
      if (cmd.refuse) begin
         status_ff <= 1'b1;
      end
      if (cmd.walk_hit) begin
         found_ff <= 1'b1;
         rv_ff    <= kv_rd_data[VAL_W-1:0];
      end
      if (cmd.emit) begin
         rsp_item_ff.found        <= found_ff;
         rsp_item_ff.result_value <= rv_ff;
         rsp_item_ff.status       <= status_ff;
      end
   end

   assign rsp_item = rsp_item_ff;

endmodule

>>> sv/chained_hash_table_engine.sv
// Hash map from signed 32-bit keys to 32-bit values with chained overflow. Each item (add,
// find, find next, clear) returns exactly one result item. After reset a clearing pass
// frees the home buckets before the first item is taken; table_size writes are accepted
// at any time. Unless the table size is zero, add and find run the djb2-xor hash and then
// a bit-serial remainder unit that reduces it modulo the bucket count; add then writes the
// entry, or refuses it when the overflow slots are full (a tail pointer per bucket makes
// it constant time), find walks the chain entries, and find next walks the chain from its
// resume point. Clear sweeps the bucket memory. The next item is accepted while a finished
// result waits.
module chained_hash_table_engine import cht_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TSZ_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_item.op),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cht_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_item  (rsp_item)
   );

endmodule

>>> sv/cht_checker.sv
module cht_checker import cht_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input rsp_type          rsp_item
);

   logic [1:0] pend_ff, pend_in;
   logic       req_acc, rsp_acc;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (req_acc && !rsp_acc) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_acc && rsp_acc) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result item without an accepted item");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items outstanding");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.found || rsp_item.result_value == '0)
      else $error("value returned without a match");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.found && rsp_item.status))
      else $error("match and refusal in one item");

endmodule

bind chained_hash_table_engine cht_checker u_cht_checker (.*);
